>>> sv/fir_pkg.sv
// fir filter shared types and constants
`timescale 1ns / 1ps

package fir_pkg;

  localparam int DATA_W = 16;
  localparam int IDX_W  = 7;
  localparam int CFG_W  = 8;
  localparam int PROD_W = 2 * DATA_W;
  localparam int FRAC_W = 15;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [CFG_W-1:0] ACTIVE_TAPS_RST = 8'd128;

  localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef struct packed {
    logic                     op;
    logic [IDX_W-1:0]         coef_index;
    logic signed [DATA_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     clipped;
  } res_t;

endpackage

>>> sv/fir_fe.sv
// fir front end: input queue port, item classification and command queue
`timescale 1ns / 1ps

module fir_fe #(
  parameter int TAP_COUNT = 128
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_push,
  output logic                                    in_full,
  input  logic                                    in_op,
  input  logic [fir_pkg::IDX_W-1:0]               in_coef_index,
  input  logic signed [fir_pkg::DATA_W-1:0]       in_coef_value,
  input  logic signed [fir_pkg::DATA_W-1:0]       in_sample_in,
  output logic                                    cmd_valid,
  input  logic                                    cmd_ready,
  output fir_pkg::cmd_t                           cmd
);

  fir_pkg::cmd_t q_r [2];
  logic          wptr_r;
  logic          rptr_r;
  logic [1:0]    cnt_r;
  logic          acc_beat;
  logic          keep;
  logic          enq;
  logic          deq;
  fir_pkg::cmd_t new_cmd;

  assign in_full  = (cnt_r == 2'd2);
  assign acc_beat = in_push && !in_full;

  // loads beyond the store are dropped here
  assign keep = (in_op == fir_pkg::OP_SAMPLE) || (32'(in_coef_index) < TAP_COUNT);
  assign enq  = acc_beat && keep;

  always_comb begin
    new_cmd.op         = in_op;
    new_cmd.coef_index = in_coef_index;
    new_cmd.data       = (in_op == fir_pkg::OP_SAMPLE) ? in_sample_in : in_coef_value;
  end

  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rptr_r];
  assign deq       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wptr_r] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (enq) begin
        wptr_r <= ~wptr_r;
      end
      if (deq) begin
        rptr_r <= ~rptr_r;
      end
      case ({enq, deq})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> sv/fir_mac.sv
// fir back end: coefficient and delay memories with one shared mac sequencer
`timescale 1ns / 1ps

module fir_mac #(
  parameter int TAP_COUNT = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [fir_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  fir_pkg::cmd_t               cmd,
  output logic                        res_valid,
  input  logic                        res_ready,
  output fir_pkg::res_t               res
);

  localparam int AW    = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int KW    = $clog2(TAP_COUNT + 1);
  localparam int NW    = (KW > fir_pkg::CFG_W) ? KW : fir_pkg::CFG_W;
  localparam int ACC_W = fir_pkg::PROD_W + $clog2(TAP_COUNT);
  localparam int RW    = ACC_W - fir_pkg::FRAC_W;
  localparam int DW    = fir_pkg::DATA_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic signed [DW-1:0] coef_mem [TAP_COUNT];
  logic signed [DW-1:0] dly_mem  [TAP_COUNT];

  logic [1:0]                    state_r, state_nxt;
  logic [fir_pkg::CFG_W-1:0]     taps_r;
  logic [AW-1:0]                 wptr_r, wptr_nxt;
  logic [AW-1:0]                 rptr_r;
  logic [KW-1:0]                 fill_r, fill_nxt;
  logic [KW-1:0]                 k_r;
  logic [KW-1:0]                 lim_r, lim_nxt;
  logic                          rd_v_r;
  logic                          mul_v_r;
  logic signed [DW-1:0]          coef_q_r;
  logic signed [DW-1:0]          dly_q_r;
  logic signed [fir_pkg::PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]       acc_r;

  logic                          take;
  logic                          start;
  logic                          issue;
  logic signed [ACC_W-1:0]       rnd;
  logic signed [RW-1:0]          rs;
  logic                          fits;

  assign cmd_ready = (state_r == S_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign start     = take && (cmd.op == fir_pkg::OP_SAMPLE);
  assign issue     = (state_r == S_RUN) && (k_r < lim_r);

  assign wptr_nxt = (wptr_r == AW'(TAP_COUNT - 1)) ? '0 : wptr_r + 1'b1;
  assign fill_nxt = (fill_r == KW'(TAP_COUNT)) ? fill_r : fill_r + 1'b1;
  // older than the first sample reads as zero, so stop at the fill count
  assign lim_nxt  = (NW'(taps_r) < NW'(fill_nxt)) ? KW'(taps_r) : fill_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_RUN;
      S_RUN:   if (!issue) state_nxt = S_DRAIN;
      S_DRAIN: if (!rd_v_r && !mul_v_r) state_nxt = S_FIN;
      S_FIN:   if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      taps_r  <= fir_pkg::ACTIVE_TAPS_RST;
      wptr_r  <= '0;
      rptr_r  <= '0;
      fill_r  <= '0;
      k_r     <= '0;
      lim_r   <= '0;
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        taps_r <= cfg_wr_data;
      end
      rd_v_r  <= issue;
      mul_v_r <= rd_v_r;
      if (start) begin
        wptr_r <= wptr_nxt;
        rptr_r <= wptr_nxt;
        fill_r <= fill_nxt;
        lim_r  <= lim_nxt;
        k_r    <= '0;
      end else if (issue) begin
        rptr_r <= (rptr_r == '0) ? AW'(TAP_COUNT - 1) : rptr_r - 1'b1;
        k_r    <= k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && (cmd.op == fir_pkg::OP_LOAD)) begin
      coef_mem[AW'(cmd.coef_index)] <= cmd.data;
    end
    if (start) begin
      dly_mem[wptr_nxt] <= cmd.data;
    end
    if (issue) begin
      coef_q_r <= coef_mem[k_r[AW-1:0]];
      dly_q_r  <= dly_mem[rptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      prod_r <= coef_q_r * dly_q_r;
    end
    if (start) begin
      acc_r <= '0;
    end else if (mul_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // round half up, then saturate
  assign rnd  = acc_r + ACC_W'(1 << (fir_pkg::FRAC_W - 1));
  assign rs   = rnd[ACC_W-1:fir_pkg::FRAC_W];
  assign fits = (&rs[RW-1:DW-1]) || !(|rs[RW-1:DW-1]);

  assign res_valid = (state_r == S_FIN);

  always_comb begin
    res.clipped = !fits;
    if (fits) begin
      res.sample = rs[DW-1:0];
    end else if (rs[RW-1]) begin
      res.sample = fir_pkg::SAMPLE_MIN;
    end else begin
      res.sample = fir_pkg::SAMPLE_MAX;
    end
  end

`ifndef SYNTHESIS
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (k_r <= lim_r))
    else $error("tap counter past limit");

  a_lim_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (lim_r <= fill_r))
    else $error("tap limit beyond filled delay line");

  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= KW'(TAP_COUNT))
    else $error("fill count overflow");

  a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (!rd_v_r && !mul_v_r))
    else $error("result shown with mac still busy");

  a_mul_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(mul_v_r) |-> $past(rd_v_r))
    else $error("product without memory read");
`endif

endmodule

>>> sv/fir_resq.sv
// fir result queue driving the output queue port
`timescale 1ns / 1ps

module fir_resq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              res_valid,
  output logic                              res_ready,
  input  fir_pkg::res_t                     res,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [fir_pkg::DATA_W-1:0] out_filtered_sample,
  output logic                              out_clipped
);

  fir_pkg::res_t q_r [2];
  logic          wptr_r;
  logic          rptr_r;
  logic [1:0]    cnt_r;
  logic          enq;
  logic          deq;

  assign res_ready           = (cnt_r != 2'd2);
  assign enq                 = res_valid && res_ready;
  assign out_empty           = (cnt_r == 2'd0);
  assign deq                 = out_pop && !out_empty;
  assign out_filtered_sample = q_r[rptr_r].sample;
  assign out_clipped         = q_r[rptr_r].clipped;

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (enq) begin
        wptr_r <= ~wptr_r;
      end
      if (deq) begin
        rptr_r <= ~rptr_r;
      end
      case ({enq, deq})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> sv/fir_filter_direct_form.sv
// flow: a sample beat passes the command queue, the mac walking n taps and then the output queue,
//   n = min(active_taps, samples seen so far, TAP_COUNT); a coefficient load only writes its memory
// throughput: a new beat is taken only once the last sample's result is queued, set by the single shared
//   multiply-accumulate that walks the coefficient and delay memories one tap per cycle
// reset: rst_n synchronous active low; queues empty, active_taps = 128, delay line reads as zeros;
//   coefficients are undefined until loaded, no clearing pass
`timescale 1ns / 1ps

module fir_filter_direct_form #(
  parameter int TAP_COUNT = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_op,
  input  logic [fir_pkg::IDX_W-1:0]         in_coef_index,
  input  logic signed [fir_pkg::DATA_W-1:0] in_coef_value,
  input  logic signed [fir_pkg::DATA_W-1:0] in_sample_in,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [fir_pkg::DATA_W-1:0] out_filtered_sample,
  output logic                              out_clipped,
  input  logic                              cfg_wr_en,
  input  logic [fir_pkg::CFG_W-1:0]         cfg_wr_data
);

  logic          cmd_valid;
  logic          cmd_ready;
  fir_pkg::cmd_t cmd;
  logic          res_valid;
  logic          res_ready;
  fir_pkg::res_t res;

  fir_fe #(
    .TAP_COUNT (TAP_COUNT)
  ) u_fe (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_sample_in  (in_sample_in),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  fir_mac #(
    .TAP_COUNT (TAP_COUNT)
  ) u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  fir_resq u_resq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .res_valid           (res_valid),
    .res_ready           (res_ready),
    .res                 (res),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_filtered_sample (out_filtered_sample),
    .out_clipped         (out_clipped)
  );

endmodule

>>> dv/tb_fir_filter_direct_form.sv
// testbench for the direct-form fir filter: directed and random beats checked against a predictor
`timescale 1ns / 1ps

module tb_fir_filter_direct_form;

  localparam int TAP_COUNT   = 128;
  localparam int DRAIN_WAIT  = 200;
  localparam int STALL_LIMIT = 20000;

  logic                              clk;
  logic                              rst_n;
  logic                              in_push;
  logic                              in_full;
  logic                              in_op;
  logic [fir_pkg::IDX_W-1:0]         in_coef_index;
  logic signed [fir_pkg::DATA_W-1:0] in_coef_value;
  logic signed [fir_pkg::DATA_W-1:0] in_sample_in;
  logic                              out_empty;
  logic                              out_pop;
  logic signed [fir_pkg::DATA_W-1:0] out_filtered_sample;
  logic                              out_clipped;
  logic                              cfg_wr_en;
  logic [fir_pkg::CFG_W-1:0]         cfg_wr_data;

  logic signed [fir_pkg::DATA_W-1:0] tap_coefs [TAP_COUNT];
  logic signed [fir_pkg::DATA_W-1:0] delay_samples [TAP_COUNT];
  logic [fir_pkg::CFG_W-1:0]         taps_in_use;
  fir_pkg::res_t                     expected_outputs [$];

  int error_count;
  int send_gap_max;
  int pop_gap_max;
  int hold_off_cycles;
  int stall_cycles;

  fir_filter_direct_form #(
    .TAP_COUNT(TAP_COUNT)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_op               (in_op),
    .in_coef_index       (in_coef_index),
    .in_coef_value       (in_coef_value),
    .in_sample_in        (in_sample_in),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_filtered_sample (out_filtered_sample),
    .out_clipped         (out_clipped),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shift in one sample and work out the rounded, saturated sum
  function automatic fir_pkg::res_t filter_sample(logic signed [fir_pkg::DATA_W-1:0] sample);
    longint        acc;
    longint        y;
    int            n;
    fir_pkg::res_t r;
    for (int k = TAP_COUNT - 1; k > 0; k--) delay_samples[k] = delay_samples[k-1];
    delay_samples[0] = sample;
    n = (int'(taps_in_use) > TAP_COUNT) ? TAP_COUNT : int'(taps_in_use);
    acc = 0;
    for (int k = 0; k < n; k++) begin
      acc += longint'(tap_coefs[k]) * longint'(delay_samples[k]);
    end
    y = (acc + (longint'(1) <<< (fir_pkg::FRAC_W - 1))) >>> fir_pkg::FRAC_W;
    r.clipped = 1'b0;
    if (y > longint'(fir_pkg::SAMPLE_MAX)) begin
      y = longint'(fir_pkg::SAMPLE_MAX);
      r.clipped = 1'b1;
    end else if (y < longint'(fir_pkg::SAMPLE_MIN)) begin
      y = longint'(fir_pkg::SAMPLE_MIN);
      r.clipped = 1'b1;
    end
    r.sample = y[fir_pkg::DATA_W-1:0];
    return r;
  endfunction

  function automatic logic signed [fir_pkg::DATA_W-1:0] random_word();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? fir_pkg::SAMPLE_MAX : fir_pkg::SAMPLE_MIN;
      1: return fir_pkg::DATA_W'($urandom_range(0, 600) - 300);
      default: return fir_pkg::DATA_W'($urandom());
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [fir_pkg::IDX_W-1:0] coef_index,
                           input logic signed [fir_pkg::DATA_W-1:0] coef_value,
                           input logic signed [fir_pkg::DATA_W-1:0] sample);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_op         <= op;
    in_coef_index <= coef_index;
    in_coef_value <= coef_value;
    in_sample_in  <= sample;
    do @(posedge clk); while (in_full);
    if (op == fir_pkg::OP_LOAD) begin
      tap_coefs[coef_index] = coef_value;
    end else begin
      expected_outputs.push_back(filter_sample(sample));
    end
  endtask

  task automatic send_load(input logic [fir_pkg::IDX_W-1:0] coef_index,
                           input logic signed [fir_pkg::DATA_W-1:0] coef_value);
    send_item(fir_pkg::OP_LOAD, coef_index, coef_value, fir_pkg::DATA_W'($urandom()));
  endtask

  task automatic send_sample(input logic signed [fir_pkg::DATA_W-1:0] sample);
    send_item(fir_pkg::OP_SAMPLE, fir_pkg::IDX_W'($urandom()), fir_pkg::DATA_W'($urandom()),
              sample);
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_active_taps(input logic [fir_pkg::CFG_W-1:0] taps);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= taps;
    @(posedge clk);
    taps_in_use = taps;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_coef_load();
    for (int k = 0; k < TAP_COUNT; k++) send_load(fir_pkg::IDX_W'(k), fir_pkg::SAMPLE_MAX);
  endtask

  task automatic test_saturation();
    repeat (3) send_sample(fir_pkg::SAMPLE_MAX);
    repeat (4) send_sample(fir_pkg::SAMPLE_MIN);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
  endtask

  task automatic test_rounding();
    set_active_taps(8'd1);
    send_load('0, 16'sd16384);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd3);
    send_sample(-16'sd3);
    send_load('0, fir_pkg::SAMPLE_MIN);
    send_sample(fir_pkg::SAMPLE_MIN);
    send_sample(fir_pkg::SAMPLE_MAX);
  endtask

  task automatic test_zero_taps();
    set_active_taps(8'd0);
    send_sample(fir_pkg::SAMPLE_MAX);
    send_sample(fir_pkg::SAMPLE_MIN);
    send_load(fir_pkg::IDX_W'(5), random_word());
    send_sample(random_word());
  endtask

  task automatic test_excess_taps();
    set_active_taps(8'd255);
    send_sample(fir_pkg::SAMPLE_MAX);
    send_sample(fir_pkg::SAMPLE_MIN);
    repeat (4) send_sample(random_word());
  endtask

  task automatic test_backpressure();
    set_active_taps(8'd2);
    send_gap_max    = 0;
    hold_off_cycles = 1500;
    repeat (60) send_sample(random_word());
    send_gap_max = 5;
  endtask

  task automatic test_random_traffic();
    logic [fir_pkg::CFG_W-1:0] taps;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: taps = 8'd1;
        1: taps = 8'd128;
        2: taps = fir_pkg::CFG_W'($urandom_range(3, 24));
        3: taps = 8'd200;
        4: taps = fir_pkg::CFG_W'($urandom_range(1, 12));
        5: taps = 8'd2;
        6: taps = fir_pkg::CFG_W'($urandom_range(1, 128));
        default: taps = fir_pkg::CFG_W'($urandom_range(4, 16));
      endcase
      set_active_taps(taps);
      // full-rate stretch on both sides
      send_gap_max = (phase == 2) ? 0 : 5;
      pop_gap_max  = (phase == 2) ? 0 : 5;
      repeat (30) begin
        if ($urandom_range(0, 3) == 0) begin
          send_load(fir_pkg::IDX_W'($urandom()), random_word());
        end else begin
          send_sample(random_word());
        end
      end
    end
    send_gap_max = 5;
    pop_gap_max  = 5;
  endtask

  // result side
  initial begin
    fir_pkg::res_t want;
    int            gap;
    out_pop = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_cycles > 0) begin
        out_pop <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else begin
        gap = $urandom_range(0, pop_gap_max);
        if (gap > 0) begin
          out_pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      if (expected_outputs.size() == 0) begin
        $error("unexpected output beat: filtered_sample %0d clipped %0b",
               out_filtered_sample, out_clipped);
        error_count++;
      end else begin
        want = expected_outputs.pop_front();
        if (out_filtered_sample !== want.sample) begin
          $error("filtered_sample: expected %0d, got %0d", want.sample, out_filtered_sample);
          error_count++;
        end
        if (out_clipped !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, out_clipped);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("fir_filter_direct_form: mismatch");
      $finish;
    end
  end

  initial begin
    error_count     = 0;
    send_gap_max    = 5;
    pop_gap_max     = 5;
    hold_off_cycles = 0;
    stall_cycles    = 0;
    taps_in_use     = fir_pkg::ACTIVE_TAPS_RST;
    for (int k = 0; k < TAP_COUNT; k++) begin
      tap_coefs[k]     = '0;
      delay_samples[k] = '0;
    end
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_op         = fir_pkg::OP_LOAD;
    in_coef_index = '0;
    in_coef_value = '0;
    in_sample_in  = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_coef_load();
    test_saturation();
    test_rounding();
    test_zero_taps();
    test_excess_taps();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    if (error_count == 0) begin
      $display("fir_filter_direct_form: match");
    end else begin
      $display("fir_filter_direct_form: mismatch");
    end
    $finish;
  end

endmodule
